// ===== hdl/rcc_pkg.sv =====
`timescale 1ns / 1ps
package rcc_pkg;

    localparam int NCOMP  = 9;
    localparam int MW     = 32;
    localparam int PW     = 64;
    localparam int CRW    = 65;
    localparam int CMAG_W = 64;
    localparam int VOL_W  = 97;
    localparam int NUM_W  = 112;
    localparam int DEN_W  = 99;
    localparam int CMP_W  = 131;
    localparam int QB     = 32;
    localparam int FSTG   = 5;
    localparam int FCNT_W = 3;

    // operand indexes per cross component: m[p]*m[q] - m[r]*m[s]
    localparam int unsigned IX [0:8][0:3] = '{
        '{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
        '{7, 2, 8, 1}, '{8, 0, 6, 2}, '{6, 1, 7, 0},
        '{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}
    };

    typedef logic [NCOMP-1:0][MW-1:0] t_mat;

    typedef struct packed {
        logic [NCOMP-1:0]             cneg;
        logic [NCOMP-1:0][CMAG_W-1:0] cmag;
        logic [VOL_W-1:0]             vmag;
        logic                         vneg;
        logic                         singular;
        logic [63:0]                  volume;
    } t_job;

endpackage

// ===== hdl/rcc_front.sv =====
`timescale 1ns / 1ps
module rcc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  rcc_pkg::t_mat                 i_m,
    output logic                          o_push,
    output rcc_pkg::t_job                 o_job,
    output logic [rcc_pkg::FCNT_W-1:0]    o_inflight
);
    import rcc_pkg::*;

    logic [FSTG-1:0] r_vld;

    logic signed [PW-1:0]  r_p1 [0:NCOMP-1];
    logic signed [PW-1:0]  r_p2 [0:NCOMP-1];
    logic signed [MW-1:0]  r_m1 [0:2];
    logic signed [CRW-1:0] r_cr2 [0:NCOMP-1];
    logic signed [MW-1:0]  r_m2 [0:2];
    logic signed [CRW-1:0] r_cr3 [0:NCOMP-1];
    logic signed [MW+MW:0] r_ph [0:2];
    logic signed [MW+MW:0] r_pl [0:2];
    logic signed [CRW-1:0] r_cr4 [0:NCOMP-1];
    logic signed [VOL_W-1:0] r_vol;
    t_job r_job;

    logic signed [VOL_W-1:0] n_vol;
    t_job n_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[FSTG-2:0], i_take};
        end
    end

    // products, cross products, partial products of the volume
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NCOMP; i++) begin
            r_p1[i]  <= $signed(i_m[IX[i][0]]) * $signed(i_m[IX[i][1]]);
            r_p2[i]  <= $signed(i_m[IX[i][2]]) * $signed(i_m[IX[i][3]]);
            r_cr2[i] <= CRW'(r_p1[i]) - CRW'(r_p2[i]);
            r_cr3[i] <= r_cr2[i];
            r_cr4[i] <= r_cr3[i];
        end
        for (int i = 0; i < 3; i++) begin
            r_m1[i] <= $signed(i_m[i]);
            r_m2[i] <= r_m1[i];
            r_ph[i] <= r_m2[i] * $signed(r_cr2[i][CRW-1:MW]);
            r_pl[i] <= r_m2[i] * $signed({1'b0, r_cr2[i][MW-1:0]});
        end
        r_vol <= n_vol;
        r_job <= n_job;
    end

    always_comb begin
        n_vol = '0;
        for (int i = 0; i < 3; i++) begin
            n_vol = n_vol + (VOL_W'(r_ph[i]) <<< MW) + VOL_W'(r_pl[i]);
        end
    end

    always_comb begin
        logic [VOL_W:0] rnd;
        logic [VOL_W-MW:0] rq;
        n_job.vneg     = r_vol[VOL_W-1];
        n_job.vmag     = n_job.vneg ? VOL_W'(-r_vol) : VOL_W'(r_vol);
        n_job.singular = (r_vol == '0);
        for (int i = 0; i < NCOMP; i++) begin
            n_job.cneg[i] = r_cr4[i][CRW-1];
            n_job.cmag[i] = r_cr4[i][CRW-1] ? CMAG_W'(-r_cr4[i]) : CMAG_W'(r_cr4[i]);
        end
        // round to Q48.16, ties away from zero, then saturate
        rnd = {1'b0, n_job.vmag} + (VOL_W+1)'(64'h8000_0000);
        rq  = rnd[VOL_W:MW];
        if (n_job.vneg) begin
            n_job.volume = (rq > (VOL_W-MW+1)'(66'h0_8000_0000_0000_0000)) ?
                64'h8000_0000_0000_0000 : 64'(-rq[63:0]);
        end else begin
            n_job.volume = (rq > (VOL_W-MW+1)'(66'h0_7FFF_FFFF_FFFF_FFFF)) ?
                64'h7FFF_FFFF_FFFF_FFFF : rq[63:0];
        end
    end

    assign o_push     = r_vld[FSTG-1];
    assign o_job      = r_job;
    assign o_inflight = FCNT_W'($countones(r_vld));

endmodule

// ===== hdl/rcc_queue.sv =====
`timescale 1ns / 1ps
module rcc_queue #(
    parameter int DEPTH = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  rcc_pkg::t_job                   i_job,
    input  logic                            i_pop,
    output logic                            o_valid,
    output rcc_pkg::t_job                   o_job,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);
    import rcc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    t_job            r_mem [0:DEPTH-1];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> r_count != CW'(DEPTH))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue read while empty");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count lost a transfer");

endmodule

// ===== hdl/rcc_back.sv =====
`timescale 1ns / 1ps
module rcc_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_job_valid,
    input  rcc_pkg::t_job                      i_job,
    output logic                               o_pop,
    input  logic                               i_stall,
    output logic                               o_valid,
    output logic [rcc_pkg::NCOMP-1:0][31:0]    o_recip,
    output logic [63:0]                        o_volume,
    output logic                               o_singular
);
    import rcc_pkg::*;

    logic                  en;
    logic [QB:0]           r_vld;
    logic [NUM_W-1:0]      r_rem  [0:QB][0:NCOMP-1];
    logic [QB-1:0]         r_q    [0:QB][0:NCOMP-1];
    logic [DEN_W-1:0]      r_den  [0:QB];
    logic [NCOMP-1:0]      r_ovf  [0:QB];
    logic [NCOMP-1:0]      r_neg  [0:QB];
    logic                  r_sing [0:QB];
    logic [63:0]           r_vol  [0:QB];

    logic [NUM_W-1:0]      n_rem  [0:QB-1][0:NCOMP-1];
    logic [QB-1:0]         n_q    [0:QB-1][0:NCOMP-1];
    logic [NUM_W-1:0]      n_num  [0:NCOMP-1];
    logic [NCOMP-1:0]      n_ovf;
    logic [NCOMP-1:0][31:0] n_recip;

    logic                  r_out_vld;
    logic [NCOMP-1:0][31:0] r_recip;
    logic [63:0]           r_out_vol;
    logic                  r_out_sing;

    assign en    = !r_out_vld || !i_stall;
    assign o_pop = en && i_job_valid;

    // numerator 2*cmag*2^46 + vmag over 2*vmag; quotient of 2^32 or more saturates
    always_comb begin
        for (int i = 0; i < NCOMP; i++) begin
            n_num[i] = NUM_W'({i_job.cmag[i], 47'b0}) + NUM_W'(i_job.vmag);
            n_ovf[i] = CMP_W'(n_num[i]) >= {i_job.vmag, 1'b0, QB'(0)};
        end
    end

    // one quotient bit per stage
    always_comb begin
        logic [CMP_W-1:0] dsh;
        logic             ge;
        for (int k = 0; k < QB; k++) begin
            for (int i = 0; i < NCOMP; i++) begin
                dsh         = CMP_W'(r_den[k]) << (QB - 1 - k);
                ge          = CMP_W'(r_rem[k][i]) >= dsh;
                n_rem[k][i] = ge ? r_rem[k][i] - dsh[NUM_W-1:0] : r_rem[k][i];
                n_q[k][i]   = {r_q[k][i][QB-2:0], ge};
            end
        end
    end

    always_comb begin
        logic [QB-1:0] lim;
        logic [QB-1:0] qs;
        for (int i = 0; i < NCOMP; i++) begin
            lim = r_neg[QB][i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            qs  = (r_ovf[QB][i] || r_q[QB][i] > lim) ? lim : r_q[QB][i];
            if (r_sing[QB]) begin
                n_recip[i] = '0;
            end else begin
                n_recip[i] = r_neg[QB][i] ? -qs : qs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[QB-1:0], i_job_valid};
            r_out_vld <= r_vld[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NCOMP; i++) begin
                r_rem[0][i] <= n_num[i];
                r_q[0][i]   <= '0;
            end
            r_den[0]  <= {i_job.vmag, 1'b0};
            r_ovf[0]  <= n_ovf;
            r_neg[0]  <= i_job.cneg ^ {NCOMP{i_job.vneg}};
            r_sing[0] <= i_job.singular;
            r_vol[0]  <= i_job.volume;
            for (int k = 0; k < QB; k++) begin
                for (int i = 0; i < NCOMP; i++) begin
                    r_rem[k+1][i] <= n_rem[k][i];
                    r_q[k+1][i]   <= n_q[k][i];
                end
                r_den[k+1]  <= r_den[k];
                r_ovf[k+1]  <= r_ovf[k];
                r_neg[k+1]  <= r_neg[k];
                r_sing[k+1] <= r_sing[k];
                r_vol[k+1]  <= r_vol[k];
            end
            r_recip    <= n_recip;
            r_out_vol  <= r_vol[QB];
            r_out_sing <= r_sing[QB];
        end
    end

    assign o_valid    = r_out_vld;
    assign o_recip    = r_recip;
    assign o_volume   = r_out_vol;
    assign o_singular = r_out_sing;

endmodule

// ===== hdl/reciprocal_cell_from_unit_cell.sv =====
`timescale 1ns / 1ps
// throughput: one matrix per cycle while o_stall is low, set by the 5-stage front, the job queue
//   and the 32-stage divider in the back (one quotient bit per stage)
// a full queue (queue fill plus front items in flight) raises o_stall
// reset: synchronous active low, clears valid bits, queue pointers and queue count only
module reciprocal_cell_from_unit_cell #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_cell_a_x,
    input  logic signed [31:0] i_cell_a_y,
    input  logic signed [31:0] i_cell_a_z,
    input  logic signed [31:0] i_cell_b_x,
    input  logic signed [31:0] i_cell_b_y,
    input  logic signed [31:0] i_cell_b_z,
    input  logic signed [31:0] i_cell_c_x,
    input  logic signed [31:0] i_cell_c_y,
    input  logic signed [31:0] i_cell_c_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_recip_a_x,
    output logic signed [31:0] o_recip_a_y,
    output logic signed [31:0] o_recip_a_z,
    output logic signed [31:0] o_recip_b_x,
    output logic signed [31:0] o_recip_b_y,
    output logic signed [31:0] o_recip_b_z,
    output logic signed [31:0] o_recip_c_x,
    output logic signed [31:0] o_recip_c_y,
    output logic signed [31:0] o_recip_c_z,
    output logic signed [63:0] o_cell_volume,
    output logic               o_singular
);
    import rcc_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH+1);

    logic                    take;
    t_mat                    m;
    logic                    push;
    t_job                    fjob;
    logic [FCNT_W-1:0]       inflight;
    logic                    q_valid;
    t_job                    q_job;
    logic                    pop;
    logic [CW-1:0]           q_count;
    logic [CW:0]             occ;
    logic [NCOMP-1:0][31:0]  recip;
    logic [63:0]             vol;

    // credit check: every item in the front already owns a queue slot
    assign occ     = (CW+1)'(q_count) + (CW+1)'(inflight);
    assign o_stall = occ >= (CW+1)'(QUEUE_DEPTH);
    assign take    = i_valid && !o_stall;

    assign m = {i_cell_c_z, i_cell_c_y, i_cell_c_x,
                i_cell_b_z, i_cell_b_y, i_cell_b_x,
                i_cell_a_z, i_cell_a_y, i_cell_a_x};

    // front: cross products, volume, signs and magnitudes
    rcc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_m        (m),
        .o_push     (push),
        .o_job      (fjob),
        .o_inflight (inflight)
    );

    // job queue decouples front from divider stalls
    rcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (fjob),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_count (q_count)
    );

    // back: pipelined division, rounding, saturation, output register
    rcc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_recip     (recip),
        .o_volume    (vol),
        .o_singular  (o_singular)
    );

    assign o_recip_a_x   = recip[0];
    assign o_recip_a_y   = recip[1];
    assign o_recip_a_z   = recip[2];
    assign o_recip_b_x   = recip[3];
    assign o_recip_b_y   = recip[4];
    assign o_recip_b_z   = recip[5];
    assign o_recip_c_x   = recip[6];
    assign o_recip_c_y   = recip[7];
    assign o_recip_c_z   = recip[8];
    assign o_cell_volume = vol;

endmodule
